>>> src/crit_pkg.sv
// Shared types and constants of the chunked image receive tracker.
package crit_pkg;

  localparam int unsigned DIV_W     = 25;
  localparam int unsigned DIVR_W    = 16;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned OUT_CNT_W = 13;

  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_CHUNK  = 3'd1,
    ACT_FINISH = 3'd2,
    ACT_ABORT  = 3'd3,
    ACT_TICK   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECV   = 2'd1,
    PH_READY  = 2'd2,
    PH_FAILED = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_NO_SESSION    = 4'd1,
    ST_WRONG_SESSION = 4'd2,
    ST_BAD_REQUEST   = 4'd3,
    ST_BAD_INDEX     = 4'd4,
    ST_BAD_CRC       = 4'd5,
    ST_WRITE_FAILED  = 4'd6,
    ST_INCOMPLETE    = 4'd7,
    ST_VERIFY_FAILED = 4'd8,
    ST_COMMIT_FAILED = 4'd9,
    ST_ERASE_FAILED  = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_EXEC,
    S_SWEEP
  } state_e;

endpackage

>>> src/chunked_image_receive_tracker_core.sv
// Top level of the chunked image receive tracker: sequencer, session state and chunk bitmap.
// For a begin that passes the size checks the result strobe follows the divider's 25 steps;
// for a chunk it follows the multiply and the bitmap read; otherwise only the execute state.
// Busy falls with the strobe unless a bitmap sweep follows; no transfer is taken while busy.
// Every 255th session clear adds a sweep of all MAX_CHUNKS bitmap entries with busy high.
// After reset all MAX_CHUNKS bitmap entries are swept with busy high; configuration
// writes are taken at any time. The receiver cannot stall, so results never wait.
module chunked_image_receive_tracker_core import crit_pkg::*; #(
  parameter int unsigned MAX_CHUNKS    = 4096,
  parameter int unsigned MAX_CHUNK_LEN = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  logic [7:0]           session_id_i,
  input  logic [23:0]          image_size_i,
  input  logic [15:0]          chunk_size_i,
  input  logic [15:0]          chunk_index_i,
  input  logic [15:0]          payload_size_i,
  input  logic [15:0]          payload_crc_i,
  input  logic [15:0]          claimed_crc_i,
  input  logic                 storage_ok_i,
  input  logic                 digest_ok_i,
  input  logic                 commit_ok_i,
  input  logic [31:0]          now_ms_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  output logic                 done_o,
  output logic [3:0]           status_o,
  output logic [1:0]           session_phase_o,
  output logic                 new_chunk_o,
  output logic [23:0]          write_offset_o,
  output logic                 release_storage_o,
  output logic [OUT_CNT_W-1:0] chunks_done_o,
  output logic [OUT_CNT_W-1:0] chunks_expected_o
);

  localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  state_e state_q, state_d;

  logic [2:0]  act_q;
  logic [7:0]  sid_q;
  logic [23:0] isize_q;
  logic [15:0] csize_q;
  logic [15:0] cidx_q;
  logic [15:0] psize_q;
  logic [15:0] pcrc_q;
  logic [15:0] ccrc_q;
  logic        stor_q;
  logic        dig_q;
  logic        com_q;
  logic [31:0] now_q;

  logic [31:0]      timeout_q;
  phase_e           phase_q, phase_d;
  logic [7:0]       tag_q, tag_d;
  logic [23:0]      img_q, img_d;
  logic [15:0]      nom_q, nom_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      last_act_q, last_act_d;
  status_e          last_st_q, last_st_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;

  logic        done_q;
  logic        newc_q, newc_d;
  logic [23:0] off_q, off_d;
  logic        rel_q, rel_d;

  logic [31:0]        prod_q;
  logic [EPOCH_W-1:0] mem_q [MAX_CHUNKS];
  logic [EPOCH_W-1:0] rd_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;
  logic               mark_we;
  logic               clr;

  logic             accept;
  logic             early_bad;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [31:0]      expect_sz;

  assign accept    = start && !busy;
  assign busy      = state_q != S_IDLE;
  assign early_bad = (image_size_i == '0) || (chunk_size_i == '0) ||
                     (32'(chunk_size_i) > 32'(MAX_CHUNK_LEN));
  assign div_start = accept && (action_e'(action_i) == ACT_BEGIN) && !early_bad;

  crit_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(image_size_i) + DIV_W'(chunk_size_i) - DIV_W'(1)),
    .divisor_i  (chunk_size_i),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_BEGIN: state_d = early_bad ? S_EXEC : S_DIV;
            ACT_CHUNK: state_d = S_MUL;
            default:   state_d = S_EXEC;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EXEC;
        end
      end
      S_MUL:   state_d = S_EXEC;
      S_EXEC:  state_d = (clr && (epoch_q == '1)) ? S_SWEEP : S_IDLE;
      S_SWEEP: begin
        if (sweep_q == IDX_W'(MAX_CHUNKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign expect_sz = ({16'b0, cidx_q} == 32'(total_q) - 32'd1) ?
                     (32'(img_q) - prod_q) : 32'(nom_q);

  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    img_d      = img_q;
    nom_d      = nom_q;
    total_d    = total_q;
    count_d    = count_q;
    last_act_d = last_act_q;
    last_st_d  = last_st_q;
    newc_d     = 1'b0;
    off_d      = '0;
    rel_d      = 1'b0;
    clr        = 1'b0;
    mark_we    = 1'b0;
    if (state_q == S_EXEC) begin
      case (action_e'(act_q))
        ACT_BEGIN: begin
          if ((isize_q == '0) || (csize_q == '0) ||
              (32'(csize_q) > 32'(MAX_CHUNK_LEN)) || (quot > DIV_W'(MAX_CHUNKS))) begin
            last_st_d = ST_BAD_REQUEST;
          end else begin
            rel_d   = phase_q == PH_RECV;
            clr     = 1'b1;
            tag_d   = '0;
            img_d   = '0;
            nom_d   = '0;
            total_d = '0;
            count_d = '0;
            if (!stor_q) begin
              phase_d   = PH_FAILED;
              last_st_d = ST_ERASE_FAILED;
            end else begin
              tag_d      = sid_q;
              img_d      = isize_q;
              nom_d      = csize_q;
              total_d    = quot[CNT_W-1:0];
              last_act_d = now_q;
              phase_d    = PH_RECV;
              last_st_d  = ST_OK;
            end
          end
        end
        ACT_CHUNK: begin
          if (phase_q != PH_RECV) begin
            last_st_d = ST_NO_SESSION;
          end else if (sid_q != tag_q) begin
            last_st_d = ST_WRONG_SESSION;
          end else if ((32'(cidx_q) >= 32'(total_q)) || (psize_q == '0) ||
                       (psize_q > nom_q)) begin
            last_st_d = ST_BAD_INDEX;
          end else if (32'(psize_q) != expect_sz) begin
            last_st_d = ST_BAD_INDEX;
          end else if (pcrc_q != ccrc_q) begin
            last_st_d = ST_BAD_CRC;
          end else begin
            last_act_d = now_q;
            off_d      = prod_q[23:0];
            if (rd_q == epoch_q) begin
              last_st_d = ST_OK;
            end else if (!stor_q) begin
              last_st_d = ST_WRITE_FAILED;
            end else begin
              mark_we   = 1'b1;
              count_d   = count_q + 1'b1;
              newc_d    = 1'b1;
              last_st_d = ST_OK;
            end
          end
        end
        ACT_FINISH: begin
          if (phase_q != PH_RECV) begin
            last_st_d = ST_NO_SESSION;
          end else begin
            last_act_d = now_q;
            if (count_q != total_q) begin
              last_st_d = ST_INCOMPLETE;
            end else if (!stor_q) begin
              phase_d   = PH_FAILED;
              last_st_d = ST_VERIFY_FAILED;
            end else if (!dig_q) begin
              rel_d     = 1'b1;
              phase_d   = PH_FAILED;
              last_st_d = ST_VERIFY_FAILED;
            end else if (!com_q) begin
              phase_d   = PH_FAILED;
              last_st_d = ST_COMMIT_FAILED;
            end else begin
              phase_d   = PH_READY;
              last_st_d = ST_OK;
            end
          end
        end
        ACT_ABORT: begin
          rel_d   = phase_q == PH_RECV;
          clr     = 1'b1;
          phase_d = PH_IDLE;
          tag_d   = '0;
          img_d   = '0;
          nom_d   = '0;
          total_d = '0;
          count_d = '0;
        end
        ACT_TICK: begin
          if ((phase_q == PH_RECV) && ((now_q - last_act_q) >= timeout_q)) begin
            rel_d     = 1'b1;
            clr       = 1'b1;
            phase_d   = PH_IDLE;
            tag_d     = '0;
            img_d     = '0;
            nom_d     = '0;
            total_d   = '0;
            count_d   = '0;
            last_st_d = ST_NO_SESSION;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    epoch_d = epoch_q;
    sweep_d = sweep_q;
    if (clr) begin
      epoch_d = (epoch_q == '1) ? EPOCH_W'(1) : epoch_q + 1'b1;
    end
    if (state_q == S_SWEEP) begin
      sweep_d = sweep_q + 1'b1;
    end else begin
      sweep_d = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cidx_q[IDX_W-1:0];
    mem_wdata = epoch_q;
    if (state_q == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else if (mark_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[cidx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      sid_q   <= session_id_i;
      isize_q <= image_size_i;
      csize_q <= chunk_size_i;
      cidx_q  <= chunk_index_i;
      psize_q <= payload_size_i;
      pcrc_q  <= payload_crc_i;
      ccrc_q  <= claimed_crc_i;
      stor_q  <= storage_ok_i;
      dig_q   <= digest_ok_i;
      com_q   <= commit_ok_i;
      now_q   <= now_ms_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= 32'(cidx_q) * 32'(nom_q);
    end
    newc_q <= newc_d;
    off_q  <= off_d;
    rel_q  <= rel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SWEEP;
      timeout_q  <= 32'd10000;
      phase_q    <= PH_IDLE;
      tag_q      <= '0;
      img_q      <= '0;
      nom_q      <= '0;
      total_q    <= '0;
      count_q    <= '0;
      last_act_q <= '0;
      last_st_q  <= ST_OK;
      epoch_q    <= EPOCH_W'(1);
      sweep_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      phase_q    <= phase_d;
      tag_q      <= tag_d;
      img_q      <= img_d;
      nom_q      <= nom_d;
      total_q    <= total_d;
      count_q    <= count_d;
      last_act_q <= last_act_d;
      last_st_q  <= last_st_d;
      epoch_q    <= epoch_d;
      sweep_q    <= sweep_d;
      done_q     <= state_q == S_EXEC;
    end
  end

  assign done_o            = done_q;
  assign status_o          = last_st_q;
  assign session_phase_o   = phase_q;
  assign new_chunk_o       = newc_q;
  assign write_offset_o    = off_q;
  assign release_storage_o = rel_q;
  assign chunks_done_o     = OUT_CNT_W'(count_q);
  assign chunks_expected_o = OUT_CNT_W'(total_q);

endmodule

>>> src/crit_div.sv
// Restoring divider that produces one quotient bit per cycle.
module crit_div import crit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q, dvs_d;
  logic [DIV_W-1:0]     dq_q, dq_d;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W:0]      diff;
  logic                 ge;

  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dvs_d = divisor_i;
      dq_d  = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      dq_d  = {dq_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

>>> src/crit_checker.sv
// Port-level checks of the chunked image receive tracker and their binding.
module crit_checker import crit_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [3:0]           status_o,
  input logic [1:0]           session_phase_o,
  input logic                 new_chunk_o,
  input logic [23:0]          write_offset_o,
  input logic                 release_storage_o,
  input logic [OUT_CNT_W-1:0] chunks_done_o,
  input logic [OUT_CNT_W-1:0] chunks_expected_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  a_new_chunk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && new_chunk_o |-> status_o == ST_OK && session_phase_o == PH_RECV)
    else $error("new chunk reported without an ok receiving session");

  a_release_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && release_storage_o |-> session_phase_o != PH_READY && !new_chunk_o)
    else $error("release reported with a ready image or a new chunk");

endmodule

bind chunked_image_receive_tracker_core crit_checker u_crit_checker (.*);
